[src/rdt_pkg.sv]
// Shared types, codes and helpers of the triangle rasterizer with depth test.
package rdt_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RED   = 2'd0,
    CFG_GREEN = 2'd1,
    CFG_BLUE  = 2'd2,
    CFG_ALPHA = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_TEST,
    ST_NUM,
    ST_DSTART,
    ST_DIV,
    ST_CMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic en;
    logic clear;
    logic sub;
  } mac_ctrl_t;

  localparam int VertexCount = 3;
  localparam int CoordW      = 12;
  localparam int DiffW       = 13;
  localparam int UW          = 28;
  localparam int AccW        = 40;
  localparam int DepthW      = 20;
  localparam int QW          = 20;
  localparam int DivW        = 47;
  localparam int DivisorW    = 27;
  localparam int ColorW      = 8;
  localparam int ShadeW      = 9;
  localparam int StepW       = 3;

  localparam logic [StepW-1:0] UX_READY = 3'd2;
  localparam logic [StepW-1:0] UY_READY = 3'd4;
  localparam logic [StepW-1:0] MUL_LAST = 3'd5;
  localparam logic [StepW-1:0] NUM_LAST = 3'd2;

  localparam logic signed [DepthW-1:0] DepthMin = {1'b1, {(DepthW-1){1'b0}}};
  localparam logic [ColorW-1:0] ColorMax = '1;

  // (c * s) >> 8, saturated to the color range
  function automatic logic [ColorW-1:0] scale_color(input logic [ColorW-1:0] c,
                                                    input logic [ShadeW-1:0] s);
    logic [ColorW+ShadeW-1:0] p;
    p = (ColorW+ShadeW)'(c) * (ColorW+ShadeW)'(s);
    return (p[ColorW+ShadeW-1] == 1'b1) ? ColorMax : p[2*ColorW-1:ColorW];
  endfunction

endpackage

[src/rdt_mac.sv]
// Shared signed multiply-accumulate unit used for edge products and depth blending.
module rdt_mac (
  input  logic                           clk,
  input  rdt_pkg::mac_ctrl_t             ctrl,
  input  logic signed [rdt_pkg::UW-1:0]  a,
  input  logic signed [rdt_pkg::DiffW-1:0] b,
  output logic signed [rdt_pkg::AccW-1:0] acc
);
  import rdt_pkg::*;

  logic signed [UW+DiffW-1:0] prod;
  logic signed [AccW-1:0]     term;
  logic signed [AccW-1:0]     base;

  always_comb begin
    prod = a * b;
    term = prod[AccW-1:0];
    base = ctrl.clear ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= ctrl.sub ? base - term : base + term;
    end
  end
endmodule

[src/rdt_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module rdt_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [rdt_pkg::DivW-1:0]           dividend,
  input  logic [rdt_pkg::DivisorW-1:0]       divisor,
  output logic                               done,
  output logic [rdt_pkg::QW-1:0]             quotient
);
  import rdt_pkg::*;

  localparam int CntW = $clog2(QW);

  logic [DivW-1:0] rem;
  logic [DivW-1:0] dsh;
  logic [CntW-1:0] cnt;
  logic            running;
  logic            fits;

  assign fits = rem >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == '0);
      if (start) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= DivW'({divisor, {(QW-1){1'b0}}});
      cnt <= CntW'(QW-1);
    end else if (running) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[QW-2:0], fits};
      dsh      <= dsh >> 1;
      cnt      <= cnt - 1'b1;
    end
  end
endmodule

[src/rdt_mem.sv]
// Depth store: one write port, one registered read port.
module rdt_mem #(
  parameter int Depth = 262144,
  parameter int AW    = 18
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic signed [rdt_pkg::DepthW-1:0] wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic signed [rdt_pkg::DepthW-1:0] rdata
);
  import rdt_pkg::*;

  logic signed [DepthW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[src/triangle_rasterizer_depth_test_core.sv]
// Triangle rasterizer with a depth test. Load words set the three vertices, a start word
// latches the intensity and opens a walk over the clipped bounding box (x outer, y inner),
// and each tick word during an open walk visits one pixel and returns one result word.
// Loads, starts and ticks with no open walk are taken while idle and leave it idle. An
// accepted tick inside a walk runs six passes through one shared multiplier for the edge
// products and one inside test; a pixel outside the triangle then goes straight to the
// output register, and one inside takes three passes for the depth blend, a divider start,
// a one-bit-per-cycle divider and one depth compare before it. Input reopens the cycle
// after the result word is loaded, so a new tick is not taken before the result word of
// the last one is loaded, and the wait grows while the result side stalls. The depth store
// is read once per visited pixel and written when the depth test passes. After reset the
// block clears all SCREEN_WIDTH*SCREEN_HEIGHT entries (262144 by default) of the depth store
// one entry per cycle and stalls input meanwhile; configuration writes are taken at any time.
module triangle_rasterizer_depth_test_core #(
  parameter int SCREEN_WIDTH  = 512,
  parameter int SCREEN_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [1:0]         vertex_index,
  input  logic signed [11:0] coord_x,
  input  logic signed [11:0] coord_y,
  input  logic signed [11:0] coord_z,
  input  logic [8:0]         shade,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [8:0]         pixel_x,
  output logic [8:0]         pixel_y,
  output logic               written,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha,
  output logic signed [19:0] pixel_depth,
  output logic               last,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import rdt_pkg::*;

  localparam int MaxDim = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int CW     = $clog2(MaxDim);
  localparam int Depth  = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW     = $clog2(Depth);

  state_t state, state_next;
  logic [StepW-1:0] step;

  logic [ColorW-1:0] color_red, color_green, color_blue, color_alpha;

  logic signed [CoordW-1:0] vx [VertexCount];
  logic signed [CoordW-1:0] vy [VertexCount];
  logic signed [CoordW-1:0] vz [VertexCount];

  logic [CW-1:0]     box_hx, box_ly, box_hy;
  logic [CW-1:0]     walk_x, walk_y;
  logic              walk_active;
  logic [ShadeW-1:0] latched_shade;

  logic signed [UW-1:0] ux, uy, uz, uw;
  logic                 neg;
  logic signed [DepthW-1:0] zq;
  logic                 wr;
  logic [AW-1:0]        clr_addr;

  logic accepted;
  assign accepted = in_valid && !in_stall;

  // bounding box of the loaded vertices, clipped to the screen
  logic signed [DiffW-1:0] min_x, max_x, min_y, max_y, lo_x, hi_x, lo_y, hi_y;
  logic box_ok;

  always_comb begin
    min_x = DiffW'(vx[0]);
    max_x = DiffW'(vx[0]);
    min_y = DiffW'(vy[0]);
    max_y = DiffW'(vy[0]);
    for (int k = 1; k < VertexCount; k++) begin
      if (DiffW'(vx[k]) < min_x) min_x = DiffW'(vx[k]);
      if (DiffW'(vx[k]) > max_x) max_x = DiffW'(vx[k]);
      if (DiffW'(vy[k]) < min_y) min_y = DiffW'(vy[k]);
      if (DiffW'(vy[k]) > max_y) max_y = DiffW'(vy[k]);
    end
    lo_x = (min_x < 0) ? '0 : min_x;
    lo_y = (min_y < 0) ? '0 : min_y;
    hi_x = (max_x > DiffW'(SCREEN_WIDTH - 1)) ? DiffW'(SCREEN_WIDTH - 1) : max_x;
    hi_y = (max_y > DiffW'(SCREEN_HEIGHT - 1)) ? DiffW'(SCREEN_HEIGHT - 1) : max_y;
    box_ok = (lo_x <= hi_x) && (lo_y <= hi_y);
  end

  // edge differences against the current pixel
  logic signed [DiffW-1:0] px, py, d_x31, d_x21, d_y31, d_y21, d_x1p, d_y1p;

  always_comb begin
    px    = $signed({{(DiffW-CW){1'b0}}, walk_x});
    py    = $signed({{(DiffW-CW){1'b0}}, walk_y});
    d_x31 = DiffW'(vx[2]) - DiffW'(vx[0]);
    d_x21 = DiffW'(vx[1]) - DiffW'(vx[0]);
    d_y31 = DiffW'(vy[2]) - DiffW'(vy[0]);
    d_y21 = DiffW'(vy[1]) - DiffW'(vy[0]);
    d_x1p = DiffW'(vx[0]) - px;
    d_y1p = DiffW'(vy[0]) - py;
  end

  // orient the weights so the area is positive
  logic signed [UW-1:0]  uz_raw, ux_f, uy_f, uz_f, uw_f;
  logic                  in_tri;
  logic signed [AccW-1:0] acc;

  always_comb begin
    uz_raw = acc[UW-1:0];
    ux_f   = uz_raw[UW-1] ? -ux : ux;
    uy_f   = uz_raw[UW-1] ? -uy : uy;
    uz_f   = uz_raw[UW-1] ? -uz_raw : uz_raw;
    uw_f   = uz_f - ux_f - uy_f;
    in_tri = (uz_f != '0) && !ux_f[UW-1] && !uy_f[UW-1] && !uw_f[UW-1];
  end

  logic [AW-1:0] idx;
  assign idx = AW'(walk_y) * AW'(SCREEN_WIDTH) + AW'(walk_x);

  logic signed [DepthW-1:0] rdata;
  logic pass;
  assign pass = zq >= rdata;

  logic last_c;
  assign last_c = (walk_x == box_hx) && (walk_y == box_hy);

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  logic div_done;
  logic [QW-1:0] quotient;
  logic [AccW-1:0] num_mag;
  assign num_mag = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == AW'(Depth - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (accepted && (op == OP_TICK) && walk_active) state_next = ST_MUL;
      ST_MUL:    if (step == MUL_LAST) state_next = ST_TEST;
      ST_TEST:   state_next = in_tri ? ST_NUM : ST_OUT;
      ST_NUM:    if (step == NUM_LAST) state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = ST_CMP;
      ST_CMP:    state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  mac_ctrl_t            mac_ctrl;
  logic signed [UW-1:0] mac_a;
  logic signed [DiffW-1:0] mac_b;
  logic                 div_start;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr;
  logic signed [DepthW-1:0] mem_wdata;
  logic                 out_load;

  always_comb begin
    in_stall  = (state != ST_IDLE);
    mac_ctrl  = '0;
    mac_a     = '0;
    mac_b     = '0;
    div_start = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx;
    mem_wdata = zq;
    out_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = DepthMin;
      end
      ST_MUL: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = !step[0];
        mac_ctrl.sub   = step[0];
        unique case (step)
          3'd0:    begin mac_a = UW'(d_x31); mac_b = d_y1p; end
          3'd1:    begin mac_a = UW'(d_x1p); mac_b = d_y31; end
          3'd2:    begin mac_a = UW'(d_x1p); mac_b = d_y21; end
          3'd3:    begin mac_a = UW'(d_x21); mac_b = d_y1p; end
          3'd4:    begin mac_a = UW'(d_x21); mac_b = d_y31; end
          default: begin mac_a = UW'(d_x31); mac_b = d_y21; end
        endcase
      end
      ST_TEST: mem_re = 1'b1;
      ST_NUM: begin
        mac_ctrl.en    = 1'b1;
        mac_ctrl.clear = (step == '0);
        unique case (step)
          3'd0:    begin mac_a = uw; mac_b = DiffW'(vz[0]); end
          3'd1:    begin mac_a = uy; mac_b = DiffW'(vz[1]); end
          default: begin mac_a = ux; mac_b = DiffW'(vz[2]); end
        endcase
      end
      ST_DSTART: div_start = 1'b1;
      ST_CMP:    mem_we = pass;
      ST_OUT:    out_load = out_free;
      default:   ;
    endcase
  end

  rdt_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .a    (mac_a),
    .b    (mac_b),
    .acc  (acc)
  );

  rdt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({num_mag[DivW-9:0], 8'b0}),
    .divisor  (uz[DivisorW-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  rdt_mem #(.Depth(Depth), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx),
    .rdata (rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      step        <= '0;
      clr_addr    <= '0;
      walk_active <= 1'b0;
      out_valid   <= 1'b0;
      color_red   <= ColorMax;
      color_green <= ColorMax;
      color_blue  <= ColorMax;
      color_alpha <= ColorMax;
      for (int k = 0; k < VertexCount; k++) begin
        vx[k] <= '0;
        vy[k] <= '0;
        vz[k] <= '0;
      end
      box_hx        <= '0;
      box_ly        <= '0;
      box_hy        <= '0;
      walk_x        <= '0;
      walk_y        <= '0;
      latched_shade <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      step <= ((state == ST_MUL) || (state == ST_NUM)) && (state_next == state)
              ? step + 1'b1 : '0;

      if (cfg_write) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_RED:   color_red   <= cfg_data;
          CFG_GREEN: color_green <= cfg_data;
          CFG_BLUE:  color_blue  <= cfg_data;
          CFG_ALPHA: color_alpha <= cfg_data;
          default:   ;
        endcase
      end

      if (accepted && (op == OP_LOAD) && (vertex_index < 2'(VertexCount))) begin
        vx[vertex_index] <= coord_x;
        vy[vertex_index] <= coord_y;
        vz[vertex_index] <= coord_z;
      end

      if (accepted && (op == OP_START)) begin
        box_hx        <= hi_x[CW-1:0];
        box_ly        <= lo_y[CW-1:0];
        box_hy        <= hi_y[CW-1:0];
        walk_x        <= lo_x[CW-1:0];
        walk_y        <= lo_y[CW-1:0];
        latched_shade <= shade;
        walk_active   <= box_ok;
      end

      // advance the walk as the result word is loaded
      if (out_load) begin
        if (last_c) begin
          walk_active <= 1'b0;
        end else if (walk_y < box_hy) begin
          walk_y <= walk_y + 1'b1;
        end else begin
          walk_y <= box_ly;
          walk_x <= walk_x + 1'b1;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state == ST_MUL) && (step == UX_READY)) ux <= acc[UW-1:0];
    if ((state == ST_MUL) && (step == UY_READY)) uy <= acc[UW-1:0];
    if (state == ST_TEST) begin
      ux <= ux_f;
      uy <= uy_f;
      uz <= uz_f;
      uw <= uw_f;
      wr <= 1'b0;
    end
    if (state == ST_DSTART) neg <= acc[AccW-1];
    if ((state == ST_DIV) && div_done) begin
      zq <= neg ? -$signed(quotient) : $signed(quotient);
    end
    if (state == ST_CMP) wr <= pass;

    if (out_load) begin
      pixel_x     <= 9'(walk_x);
      pixel_y     <= 9'(walk_y);
      written     <= wr;
      out_red     <= wr ? scale_color(color_red, latched_shade) : '0;
      out_green   <= wr ? scale_color(color_green, latched_shade) : '0;
      out_blue    <= wr ? scale_color(color_blue, latched_shade) : '0;
      out_alpha   <= wr ? color_alpha : '0;
      pixel_depth <= wr ? zq : '0;
      last        <= last_c;
    end
  end
endmodule

[src/rdt_checker.sv]
// Port-level checks of the rasterizer core and their binding.
module rdt_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         op,
  input logic               out_valid,
  input logic               out_stall,
  input logic [8:0]         pixel_x,
  input logic [8:0]         pixel_y,
  input logic               written,
  input logic [7:0]         out_red,
  input logic [7:0]         out_green,
  input logic [7:0]         out_blue,
  input logic [7:0]         out_alpha,
  input logic signed [19:0] pixel_depth
);
  import rdt_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled result word changed");

  // loads and starts never produce a word
  a_no_word_from_setup: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op == OP_LOAD || op == OP_START) |=> !$rose(out_valid))
    else $error("result word from a non-tick input");

  // a skipped pixel carries zero color and depth
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !written |-> out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0
                              && out_alpha == 8'd0 && pixel_depth == 20'sd0)
    else $error("skipped pixel with nonzero payload");

  // a new word only comes out of a busy sequencer
  a_word_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared while input was open");
endmodule

bind triangle_rasterizer_depth_test_core rdt_checker u_rdt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .op          (op),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pixel_x     (pixel_x),
  .pixel_y     (pixel_y),
  .written     (written),
  .out_red     (out_red),
  .out_green   (out_green),
  .out_blue    (out_blue),
  .out_alpha   (out_alpha),
  .pixel_depth (pixel_depth)
);

[tb/triangle_rasterizer_depth_test_core_test.sv]
// Self-checking testbench for the triangle rasterizer with depth test.
`timescale 1ns / 100ps

module triangle_rasterizer_depth_test_core_test;
  import rdt_pkg::*;

  localparam int Width     = 512;
  localparam int Height    = 512;
  localparam int CycleCap  = 3000000;
  localparam int DrainWait = 60;

  typedef struct {
    op_t               op;
    logic [1:0]        vi;
    logic signed [11:0] x, y, z;
    logic [8:0]        shade;
  } vert_word_t;

  typedef struct {
    logic [8:0]         px, py;
    logic               wr;
    logic [7:0]         r, g, b, a;
    logic signed [19:0] depth;
    logic               fin;
  } pixel_word_t;

  logic               clk, rst;
  logic               in_valid, in_stall;
  logic [1:0]         op, vertex_index;
  logic signed [11:0] coord_x, coord_y, coord_z;
  logic [8:0]         shade;
  logic               out_valid, out_stall;
  logic [8:0]         pixel_x, pixel_y;
  logic               written, last;
  logic [7:0]         out_red, out_green, out_blue, out_alpha;
  logic signed [19:0] pixel_depth;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [7:0]         cfg_data;

  triangle_rasterizer_depth_test_core dut (.*);

  vert_word_t  pending_words[$];
  pixel_word_t expected_pixels[$];
  int          errors, cycles, send_gap, stall_left;
  bit          calm, hold_sender;

  // shadow state of the rasterizer
  int          vx[3], vy[3], vz[3];
  int          box_hx, box_ly, box_hy, walk_x, walk_y;
  bit          walking;
  int unsigned lshade;
  logic [7:0]  col_r, col_g, col_b, col_a;
  logic signed [19:0] zbuf [0:Width*Height-1];

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [7:0] shaded(logic [7:0] c, int unsigned s);
    int unsigned v;
    v = (c * s) >> 8;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic rasterize(vert_word_t w);
    longint ux, uy, uz, num, zl;
    int     lx, hx, ly, hy, zq, idx;
    bit     wr, fin;
    pixel_word_t p;
    case (w.op)
      OP_LOAD: begin
        if (w.vi < 3) begin
          vx[w.vi] = w.x; vy[w.vi] = w.y; vz[w.vi] = w.z;
        end
      end
      OP_START: begin
        lx = vx[0]; hx = vx[0]; ly = vy[0]; hy = vy[0];
        for (int k = 1; k < 3; k++) begin
          if (vx[k] < lx) lx = vx[k];
          if (vx[k] > hx) hx = vx[k];
          if (vy[k] < ly) ly = vy[k];
          if (vy[k] > hy) hy = vy[k];
        end
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (hx > Width - 1) hx = Width - 1;
        if (hy > Height - 1) hy = Height - 1;
        box_hx = hx; box_ly = ly; box_hy = hy;
        lshade = w.shade;
        walk_x = lx; walk_y = ly;
        walking = (lx <= hx) && (ly <= hy);
      end
      OP_TICK: begin
        if (walking) begin
          ux = longint'(vx[2] - vx[0]) * (vy[0] - walk_y)
             - longint'(vx[0] - walk_x) * (vy[2] - vy[0]);
          uy = longint'(vx[0] - walk_x) * (vy[1] - vy[0])
             - longint'(vx[1] - vx[0]) * (vy[0] - walk_y);
          uz = longint'(vx[1] - vx[0]) * (vy[2] - vy[0])
             - longint'(vx[2] - vx[0]) * (vy[1] - vy[0]);
          if (uz < 0) begin
            ux = -ux; uy = -uy; uz = -uz;
          end
          wr = 0;
          zq = 0;
          if (uz != 0 && ux >= 0 && uy >= 0 && uz - ux - uy >= 0) begin
            num = longint'(vz[0]) * (uz - ux - uy) + longint'(vz[1]) * uy
                + longint'(vz[2]) * ux;
            zl = (num * 256) / uz;
            zq = int'(zl);
            idx = walk_x + walk_y * Width;
            if (zq >= int'(zbuf[idx])) begin
              zbuf[idx] = zq[19:0];
              wr = 1;
            end
          end
          fin = (walk_x == box_hx) && (walk_y == box_hy);
          p.px    = walk_x[8:0];
          p.py    = walk_y[8:0];
          p.wr    = wr;
          p.r     = wr ? shaded(col_r, lshade) : 8'd0;
          p.g     = wr ? shaded(col_g, lshade) : 8'd0;
          p.b     = wr ? shaded(col_b, lshade) : 8'd0;
          p.a     = wr ? col_a : 8'd0;
          p.depth = wr ? zq[19:0] : 20'sd0;
          p.fin   = fin;
          expected_pixels.push_back(p);
          if (fin) walking = 0;
          else if (walk_y < box_hy) walk_y++;
          else begin
            walk_y = box_ly;
            walk_x++;
          end
        end
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    vert_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        rasterize('{op_t'(op), vertex_index, coord_x, coord_y, coord_z, shade});
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0 && !hold_sender) begin
          w = pending_words.pop_front();
          op           <= w.op;
          vertex_index <= w.vi;
          coord_x      <= w.x;
          coord_y      <= w.y;
          coord_z      <= w.z;
          shade        <= w.shade;
          in_valid     <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_word_t e;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel word x=%0d y=%0d", pixel_x, pixel_y);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (pixel_x !== e.px) begin
            $error("pixel_x exp %0d got %0d", e.px, pixel_x); errors++;
          end
          if (pixel_y !== e.py) begin
            $error("pixel_y exp %0d got %0d", e.py, pixel_y); errors++;
          end
          if (written !== e.wr) begin
            $error("written exp %0d got %0d", e.wr, written); errors++;
          end
          if (out_red !== e.r) begin
            $error("out_red exp %0d got %0d", e.r, out_red); errors++;
          end
          if (out_green !== e.g) begin
            $error("out_green exp %0d got %0d", e.g, out_green); errors++;
          end
          if (out_blue !== e.b) begin
            $error("out_blue exp %0d got %0d", e.b, out_blue); errors++;
          end
          if (out_alpha !== e.a) begin
            $error("out_alpha exp %0d got %0d", e.a, out_alpha); errors++;
          end
          if (pixel_depth !== e.depth) begin
            $error("pixel_depth exp %0d got %0d", e.depth, pixel_depth); errors++;
          end
          if (last !== e.fin) begin
            $error("last exp %0d got %0d", e.fin, last); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap();
        out_stall <= (stall_left > 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleCap) begin
      $display("[triangle_rasterizer_depth_test_core] ERROR");
      $finish;
    end
  end

  task automatic push_word(op_t o, int vi, int x, int y, int z, int s);
    vert_word_t w;
    w.op = o; w.vi = vi[1:0]; w.x = x[11:0]; w.y = y[11:0]; w.z = z[11:0];
    w.shade = s[8:0];
    pending_words.push_back(w);
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_word(OP_TICK, 0, 0, 0, 0, 0);
  endtask

  task automatic set_reg(cfg_idx_t idx, logic [7:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      CFG_RED:   col_r = v;
      CFG_GREEN: col_g = v;
      CFG_BLUE:  col_b = v;
      default:   col_a = v;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_colors(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    set_reg(CFG_RED, r);
    set_reg(CFG_GREEN, g);
    set_reg(CFG_BLUE, b);
    set_reg(CFG_ALPHA, a);
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // one small triangle near a random base, walked in full (at times with one tick more), cut short or reloaded halfway
  task automatic push_triangle();
    int bx, by, zc, xs[3], ys[3], lx, hx, ly, hy, n, s, r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      bx = $urandom_range(0, 24); by = $urandom_range(0, 24);
    end else if (r < 9) begin
      bx = $urandom_range(0, 505); by = $urandom_range(0, 505);
    end else begin
      bx = $urandom_range(0, 1) ? $urandom_range(505, 511) : -int'($urandom_range(0, 4));
      by = $urandom_range(0, 1) ? $urandom_range(505, 511) : -int'($urandom_range(0, 4));
    end
    zc = int'($urandom_range(0, 4095)) - 2048;
    for (int k = 0; k < 3; k++) begin
      xs[k] = bx + $urandom_range(0, 5);
      ys[k] = by + $urandom_range(0, 5);
      push_word(OP_LOAD, k, xs[k], ys[k],
                $urandom_range(0, 3) == 0 ? zc : int'($urandom_range(0, 4095)) - 2048, 0);
    end
    lx = xs[0]; hx = xs[0]; ly = ys[0]; hy = ys[0];
    for (int k = 1; k < 3; k++) begin
      lx = (xs[k] < lx) ? xs[k] : lx; hx = (xs[k] > hx) ? xs[k] : hx;
      ly = (ys[k] < ly) ? ys[k] : ly; hy = (ys[k] > hy) ? ys[k] : hy;
    end
    lx = (lx < 0) ? 0 : lx; ly = (ly < 0) ? 0 : ly;
    hx = (hx > Width - 1) ? Width - 1 : hx; hy = (hy > Height - 1) ? Height - 1 : hy;
    n = (hx >= lx && hy >= ly) ? (hx - lx + 1) * (hy - ly + 1) : 0;
    s = ($urandom_range(0, 4) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
    push_word(OP_START, 0, 0, 0, 0, s);
    if ($urandom_range(0, 9) == 0) begin
      // change a vertex halfway through the walk
      push_ticks(n / 2);
      push_word(OP_LOAD, $urandom_range(0, 2), bx + $urandom_range(0, 5),
                by + $urandom_range(0, 5), int'($urandom_range(0, 4095)) - 2048, 0);
      push_ticks(n - n / 2);
    end else if ($urandom_range(0, 9) == 0) begin
      push_ticks($urandom_range(0, n));
    end else begin
      push_ticks(n + $urandom_range(0, 1));
    end
  endtask

  task automatic push_noise();
    push_word(op_t'($urandom_range(0, 3)), $urandom_range(0, 3),
              $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int base;
    rst = 1'b1;
    in_valid = 1'b0; out_stall = 1'b0; cfg_write = 1'b0;
    cfg_index = CFG_RED; cfg_data = '0;
    op = OP_NONE; vertex_index = '0; coord_x = '0; coord_y = '0; coord_z = '0;
    shade = '0;
    errors = 0; cycles = 0; calm = 0; hold_sender = 0;
    for (int k = 0; k < 3; k++) begin
      vx[k] = 0; vy[k] = 0; vz[k] = 0;
    end
    box_hx = 0; box_ly = 0; box_hy = 0;
    walk_x = 0; walk_y = 0; walking = 0; lshade = 0;
    col_r = 8'd255; col_g = 8'd255; col_b = 8'd255; col_a = 8'd255;
    for (int k = 0; k < Width * Height; k++) zbuf[k] = DepthMin;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_colors(8'd200, 8'd100, 8'd50, 8'd170);
    // directed words
    push_ticks(1);                                   // tick with no walk open
    push_word(OP_NONE, 3, -1, -1, -1, 511);           // unused op code
    push_word(OP_LOAD, 3, -2048, 2047, -2048, 0);     // vertex index three
    push_word(OP_LOAD, 0, -2048, -2048, 2047, 0);     // huge triangle, clipped
    push_word(OP_LOAD, 1, 2047, -2048, -2048, 0);
    push_word(OP_LOAD, 2, -2048, 2047, 0, 0);
    push_word(OP_START, 0, 0, 0, 0, 256);
    push_ticks(3);
    push_word(OP_LOAD, 0, 0, 0, 5, 0);                // restart while walking
    push_word(OP_LOAD, 1, 2, 0, -7, 0);
    push_word(OP_LOAD, 2, 0, 2, 9, 0);
    push_word(OP_START, 0, 0, 0, 0, 511);             // saturating shade
    push_ticks(4);
    push_word(OP_LOAD, 2, 0, 1, 9, 0);                // load during walk
    push_ticks(5);
    push_word(OP_LOAD, 2, 2, 2, 0, 0);                // new third vertex, fresh walk
    push_word(OP_START, 0, 0, 0, 0, 0);
    push_ticks(2);
    push_word(OP_LOAD, 2, 0, 2, 9, 0);
    push_word(OP_LOAD, 1, -5, -1, -1, 0);             // empty box
    push_word(OP_LOAD, 0, -5, -1, -1, 0);
    push_word(OP_LOAD, 2, -1, -5, -1, 0);
    push_word(OP_START, 0, 0, 0, 0, 128);
    push_ticks(1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_colors(8'd0, 8'd0, 8'd0, 8'd0);
        1: set_colors(8'd255, 8'd255, 8'd255, 8'd255);
        2: set_colors(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: set_colors(8'd128, 8'd1, 8'd254, 8'd77);
      endcase
      calm = (phase == 2);
      base = pending_words.size();
      while (pending_words.size() < base + 100) begin
        if ($urandom_range(0, 9) == 0) push_noise();
        else push_triangle();
      end
      if (phase == 1) begin
        // hold the sender until every pixel word has come back
        while (pending_words.size() > base + 50) @(posedge clk);
        hold_sender = 1;
        while (in_valid || expected_pixels.size() > 0) @(posedge clk);
        hold_sender = 0;
      end
      drain();
    end

    if (errors == 0) $display("[triangle_rasterizer_depth_test_core] OK");
    else $display("[triangle_rasterizer_depth_test_core] ERROR");
    $finish;
  end

endmodule

[sim.f]
src/rdt_pkg.sv
src/rdt_mac.sv
src/rdt_div.sv
src/rdt_mem.sv
src/triangle_rasterizer_depth_test_core.sv
src/rdt_checker.sv
tb/triangle_rasterizer_depth_test_core_test.sv
